>>> rtl/svt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// svt_pkg: shared constants and types for the sorted value table
// Table capacity, derived widths and the action codes of the input stream.
// ---------------------------------------------------------------------------
package svt_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int FIELD_W  = 7;  // width of match_count and entries_held

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_COUNT  = 2'd2,
		ACT_MEMBER = 2'd3
	} action_t;

endpackage
`default_nettype wire

>>> rtl/sorted_value_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_value_table: descending table of signed values with four actions
// Insert, remove all equal, count equal and membership test on one value,
// using a single entry memory walked once per item.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                        | tuser
//  ---------+-----+-------------------------------------------+-------------
//  s_*      | in  | value[31:0]                               | action[1:0]
//  m_*      | out | found, match_count[6:0], entries_held[6:0] | status
//
// Each item is walked once from acceptance to its result being offered: one
// read of each entry held through the registered memory port, taking in the
// last read, seeing the walk end, the tail write and count update, and the
// output load. The next item is accepted only after that load, so items do
// not overlap inside the block.
// The next item may be accepted while the previous result still waits on m_*.
// Reset empties the table at once; the memory contents need no clearing.
// A stalled m_tready holds the result and keeps the next item from finishing.
// ---------------------------------------------------------------------------
module sorted_value_table (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire  [svt_pkg::VALUE_W-1:0] s_tdata,   // value[31:0]
	input  wire  [1:0]                  s_tuser,   // action[1:0]
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [15:0]                 m_tdata,   // found, match_count, entries_held, pad
	output logic [0:0]                  m_tuser    // status
);
	import svt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_DONE
	} state_t;

	state_t                state_q;
	action_t               act_q;
	logic [VALUE_W-1:0]    val_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  valid_s1;
	logic [ADDR_W-1:0]     idx_s1;
	logic [VALUE_W-1:0]    rd_data_s1;
	logic [CNT_W-1:0]      eq_cnt_q;
	logic [CNT_W-1:0]      kept_q;
	logic                  placed_q;
	logic [VALUE_W-1:0]    carry_q;
	logic                  full_q;
	logic                  res_found_q;
	logic [CNT_W-1:0]      res_match_q;
	logic                  res_status_q;
	logic                  m_tvalid_q;
	logic [15:0]           m_tdata_q;
	logic                  m_tuser_q;

	logic [VALUE_W-1:0]    entry_mem_q [CAPACITY];

	logic                  rd_en;
	logic                  eq;
	logic                  lower;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [VALUE_W-1:0]    wr_data;
	logic                  ins_live;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Issue one read per cycle while entries remain
	assign rd_en    = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign eq       = (rd_data_s1 == val_q);
	assign lower    = ($signed(rd_data_s1) < $signed(val_q));
	assign ins_live = (act_q == ACT_INSERT) && !full_q;

	// Write-back: compaction for remove, ripple shift for insert
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data_s1;
		if (state_q == ST_SCAN && valid_s1) begin
			case (act_q)
				ACT_REMOVE: begin
					if (!eq) begin
						wr_en   = 1'b1;
						wr_addr = kept_q[ADDR_W-1:0];
					end
				end
				ACT_INSERT: begin
					if (!full_q && placed_q) begin
						wr_en   = 1'b1;
						wr_data = carry_q;
					end else if (!full_q && lower) begin
						wr_en   = 1'b1;
						wr_data = val_q;
					end
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end else if (state_q == ST_FINISH && ins_live) begin
			// Append the last displaced entry, or the new value at the tail
			wr_en   = 1'b1;
			wr_addr = count_q[ADDR_W-1:0];
			wr_data = placed_q ? carry_q : val_q;
		end
	end

	// Entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= entry_mem_q[rd_idx_q[ADDR_W-1:0]];
		end
	end

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= ACT_INSERT;
			val_q        <= '0;
			count_q      <= '0;
			rd_idx_q     <= '0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			eq_cnt_q     <= '0;
			kept_q       <= '0;
			placed_q     <= 1'b0;
			carry_q      <= '0;
			full_q       <= 1'b0;
			res_found_q  <= 1'b0;
			res_match_q  <= '0;
			res_status_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= 1'b0;
		end else begin
			// Drop the result once it is transferred, unless a new one loads
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						act_q    <= action_t'(s_tuser);
						val_q    <= s_tdata;
						rd_idx_q <= '0;
						valid_s1 <= 1'b0;
						eq_cnt_q <= '0;
						kept_q   <= '0;
						placed_q <= 1'b0;
						full_q   <= (count_q >= CNT_W'(CAPACITY));
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					valid_s1 <= rd_en;
					idx_s1   <= rd_idx_q[ADDR_W-1:0];
					if (valid_s1) begin
						eq_cnt_q <= eq_cnt_q + CNT_W'(eq);
						kept_q   <= kept_q + CNT_W'(!eq);
						if (ins_live && (placed_q || lower)) begin
							carry_q  <= rd_data_s1;
							placed_q <= 1'b1;
						end
					end
					if (!rd_en && !valid_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					res_match_q <= eq_cnt_q;
					case (act_q)
						ACT_INSERT: begin
							res_status_q <= full_q;
							res_found_q  <= !full_q || (eq_cnt_q != '0);
							if (!full_q) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						ACT_REMOVE: begin
							res_status_q <= 1'b0;
							res_found_q  <= 1'b0;
							count_q      <= kept_q;
						end
						default: begin
							res_status_q <= 1'b0;
							res_found_q  <= (eq_cnt_q != '0);
						end
					endcase
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Load the result when the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, FIELD_W'(count_q), FIELD_W'(res_match_q),
							res_found_q};
						m_tuser_q  <= res_status_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/svt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// svt_checker: port-level checks for the sorted value table
// Watches the stream ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
module svt_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         s_tvalid,
	input wire                         s_tready,
	input wire                         m_tvalid,
	input wire                         m_tready,
	input wire  [15:0]                 m_tdata,
	input wire  [0:0]                  m_tuser
);
	import svt_pkg::*;

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Take one item at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is at work");

	// A dropped insert only happens at a full table
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[14:8] == FIELD_W'(CAPACITY))
		else $error("insert dropped below capacity");

	// A found value means the table is not empty
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[14:8] != '0)
		else $error("found reported on an empty table");

endmodule

bind sorted_value_table svt_checker u_svt_checker (.*);
`default_nettype wire
